// ----- hdl/lrufc_pkg.sv -----
package lrufc_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 32;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W = 5;
  localparam int REQ_W = 32;
  localparam int MISS_W = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 2'd1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic {
    POLICY_LRU  = 1'b0,
    POLICY_FIFO = 1'b1
  } policy_e;

  // controller -> datapath
  typedef struct packed {
    logic load_key;
    logic look;
    logic move_hit;
    logic count_miss;
    logic evict;
    logic append;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic lru;
    logic must_evict;
  } status_t;

  // sign-extend the request, then keep the low KEY_BITS bits
  function automatic logic [KEY_BITS-1:0] key_of(input logic [REQ_W-1:0] req);
    logic [63:0] ext;
    ext = {{(64 - REQ_W){req[REQ_W-1]}}, req};
    return ext[KEY_BITS-1:0];
  endfunction

endpackage

// ----- hdl/lrufc_ctrl.sv -----
module lrufc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  lrufc_pkg::status_t   status_i,
  output lrufc_pkg::cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_APPLY = 5'b00100,
    S_EVICT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_key = 1'b1;
          state_d        = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_APPLY;
      end
      S_APPLY: begin
        if (status_i.hit) begin
          cmd_o.move_hit = status_i.lru;
          state_d        = S_DONE;
        end else begin
          cmd_o.count_miss = 1'b1;
          state_d          = S_EVICT;
        end
      end
      S_EVICT: begin
        // drop the oldest entry one per cycle until there is room
        if (status_i.must_evict) begin
          cmd_o.evict = 1'b1;
        end else begin
          cmd_o.append = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.load_out)              out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_LOOK))
    else $error("accepted request did not start a lookup");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

// ----- hdl/lrufc_dp.sv -----
module lrufc_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lrufc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lrufc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic signed [lrufc_pkg::REQ_W-1:0]   request_key_i,
  input  lrufc_pkg::cmd_t                      cmd_i,
  output lrufc_pkg::status_t                   status_o,
  output logic                                 hit_o,
  output logic [lrufc_pkg::MISS_W-1:0]         miss_total_o
);

  logic [lrufc_pkg::CAP_W-1:0]    capacity_q;
  lrufc_pkg::policy_e             policy_q;

  logic [lrufc_pkg::KEY_BITS-1:0] keys_q [lrufc_pkg::DEPTH];
  logic [lrufc_pkg::KEY_BITS-1:0] keys_d [lrufc_pkg::DEPTH];
  logic [lrufc_pkg::KEY_BITS-1:0] shl    [lrufc_pkg::DEPTH];
  logic [lrufc_pkg::KEY_BITS-1:0] key_q;
  logic [lrufc_pkg::CNT_W-1:0]    occ_q, occ_d, occ_last;
  logic [lrufc_pkg::MISS_W-1:0]   miss_q;
  logic                           hit_q;
  logic [lrufc_pkg::IDX_W-1:0]    where_q;
  logic                           out_hit_q;
  logic [lrufc_pkg::MISS_W-1:0]   out_miss_q;

  logic [lrufc_pkg::DEPTH-1:0]    match;
  logic                           found;
  logic [lrufc_pkg::IDX_W-1:0]    where_d;
  logic [lrufc_pkg::CNT_W-1:0]    cap_eff;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lrufc_pkg::CAPACITY_RESET;
      policy_q   <= lrufc_pkg::POLICY_LRU;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lrufc_pkg::REG_CAPACITY: capacity_q <= cfg_wdata_i[lrufc_pkg::CAP_W-1:0];
        lrufc_pkg::REG_POLICY:   policy_q   <= lrufc_pkg::policy_e'(cfg_wdata_i[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (capacity_q == '0)
      cap_eff = lrufc_pkg::CNT_W'(1);
    else if (32'(capacity_q) > lrufc_pkg::DEPTH)
      cap_eff = lrufc_pkg::CNT_W'(lrufc_pkg::DEPTH);
    else
      cap_eff = lrufc_pkg::CNT_W'(capacity_q);
  end

  // tag compare across valid entries, first match wins
  always_comb begin
    for (int i = 0; i < lrufc_pkg::DEPTH; i++) begin
      match[i] = (lrufc_pkg::CNT_W'(i) < occ_q) && (keys_q[i] == key_q);
    end
    found   = |match;
    where_d = '0;
    for (int i = lrufc_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match[i]) where_d = lrufc_pkg::IDX_W'(i);
    end
  end

  assign status_o.hit        = hit_q;
  assign status_o.lru        = (policy_q == lrufc_pkg::POLICY_LRU);
  assign status_o.must_evict = (occ_q >= cap_eff) && (occ_q != '0);

  assign occ_last = occ_q - lrufc_pkg::CNT_W'(1);

  always_comb begin
    for (int i = 0; i < lrufc_pkg::DEPTH - 1; i++) begin
      shl[i] = keys_q[i + 1];
    end
    shl[lrufc_pkg::DEPTH-1] = keys_q[lrufc_pkg::DEPTH-1];
  end

  always_comb begin
    occ_d = occ_q;
    for (int i = 0; i < lrufc_pkg::DEPTH; i++) begin
      keys_d[i] = keys_q[i];
      if (cmd_i.evict) begin
        keys_d[i] = shl[i];
      end else if (cmd_i.move_hit) begin
        // close the gap at the hit and put the key at the recent end
        if (lrufc_pkg::CNT_W'(i) == occ_last)
          keys_d[i] = key_q;
        else if ((lrufc_pkg::CNT_W'(i) >= lrufc_pkg::CNT_W'(where_q)) &&
                 (lrufc_pkg::CNT_W'(i) < occ_last))
          keys_d[i] = shl[i];
      end else if (cmd_i.append) begin
        if (lrufc_pkg::CNT_W'(i) == occ_q) keys_d[i] = key_q;
      end
    end
    if (cmd_i.evict)
      occ_d = occ_last;
    else if (cmd_i.append)
      occ_d = occ_q + lrufc_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < lrufc_pkg::DEPTH; i++) begin
      keys_q[i] <= keys_d[i];
    end
    if (cmd_i.load_key) key_q <= lrufc_pkg::key_of(request_key_i);
    if (cmd_i.look) begin
      hit_q   <= found;
      where_q <= where_d;
    end
    if (cmd_i.load_out) begin
      out_hit_q  <= hit_q;
      out_miss_q <= miss_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      miss_q <= '0;
    end else begin
      occ_q <= occ_d;
      if (cmd_i.count_miss && (miss_q != '1)) miss_q <= miss_q + lrufc_pkg::MISS_W'(1);
    end
  end

  assign hit_o        = out_hit_q;
  assign miss_total_o = out_miss_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= lrufc_pkg::DEPTH)
    else $error("occupancy above depth");

  a_evict_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.evict |-> (occ_q != '0))
    else $error("eviction from an empty cache");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> (occ_q < cap_eff))
    else $error("append into a full cache");

endmodule

// ----- hdl/lru_fifo_cache_replacement.sv -----
// Fully associative cache replacement engine, LRU or FIFO order, holding up
// to lrufc_pkg::DEPTH keys (capacity register, clamped to 1..DEPTH). Each
// accepted request gives one result: hit flag and saturating miss total.
// One request is in flight at a time. A hit passes through accept,
// registered tag compare, order update (LRU only) and result; a miss
// passes through accept, tag compare, miss count, an eviction loop that
// drops the oldest entry one per cycle until there is room, append, result.
// A finished result sits in an output register, so the next request is
// taken while it waits. Configure only while idle.
module lru_fifo_cache_replacement (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lrufc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lrufc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lrufc_pkg::REQ_W-1:0]  request_key_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [lrufc_pkg::MISS_W-1:0]        miss_total_o
);

  lrufc_pkg::cmd_t    cmd;
  lrufc_pkg::status_t status;

  lrufc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lrufc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .request_key_i (request_key_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .hit_o         (hit_o),
    .miss_total_o  (miss_total_o)
  );

endmodule
